@@ hw/rtl/m4ct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// m4ct_pkg
// Shared types and constants for the 4x4 column-major matrix-vector transform.
// ----------------------------------------------------------------------------
package m4ct_pkg;

    // widths of one element, one register and the register index
    localparam int DATA_W    = 32;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MAX_DIM   = 4;

    // four full-width products plus rounding need two guard bits
    localparam int ACC_W = 2 * DATA_W + 2;

    // parameter defaults
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIM_DEF       = 4;

    // saturation limits
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // register reset values form the identity matrix
    localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
        64'h0001_0000_0000_0000,  // col3 rows 2/3
        64'h0000_0000_0000_0000,  // col3 rows 0/1
        64'h0000_0000_0001_0000,  // col2 rows 2/3
        64'h0000_0000_0000_0000,  // col2 rows 0/1
        64'h0000_0000_0000_0000,  // col1 rows 2/3
        64'h0001_0000_0000_0000,  // col1 rows 0/1
        64'h0000_0000_0000_0000,  // col0 rows 2/3
        64'h0000_0000_0001_0000   // col0 rows 0/1
    };

    // one signed q16.16 element
    typedef logic signed [DATA_W-1:0] t_q;

    // matrix as [column][row]
    typedef t_q [MAX_DIM-1:0][MAX_DIM-1:0] t_mat;

    // input beat
    typedef struct packed {
        logic signed [DATA_W-1:0] in_x;
        logic signed [DATA_W-1:0] in_y;
        logic signed [DATA_W-1:0] in_z;
        logic signed [DATA_W-1:0] in_w;
    } t_vec_in;

    // output beat
    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic                     saturated;
    } t_vec_out;

endpackage
`default_nettype wire

@@ hw/rtl/m4ct_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// m4ct_regs
// Matrix register file: eight 64-bit write-only registers, two entries each,
// presented as a 4x4 column-major matrix.
// ----------------------------------------------------------------------------
module m4ct_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [m4ct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [m4ct_pkg::REG_W-1:0]            i_cfg_data,
    output m4ct_pkg::t_mat                             o_mat
);
    import m4ct_pkg::*;

    logic [NUM_REGS-1:0][REG_W-1:0] r_regs;

    // register writes, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end

    // register 2*col holds rows 0/1, register 2*col+1 rows 2/3
    for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
        for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
            assign o_mat[c][r] = r_regs[c * 2 + r / 2][(r % 2) * DATA_W +: DATA_W];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/mat4_column_transform.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat4_column_transform
// Configured 4x4 column-major matrix times a stream of q16.16 column vectors.
// ----------------------------------------------------------------------------
// Takes one vector beat per clock while o_stall is low and returns one result beat
// per vector, in order. An accepted beat reaches o_valid through these registers
// in turn: one stage registers the vector, one holds the sixteen 32x32 products,
// one the pairwise sums, one the full sum with the rounding half added, and the
// output register holds the shifted, saturated rows. Each stage only waits when
// the one after it is full and stalled, so bubbles close up and the input keeps
// taking beats while a result sits in the output register. Matrix writes land
// the next cycle and should be made only while no vector is in flight.
// ----------------------------------------------------------------------------
module mat4_column_transform #(
    parameter int FRAC_BITS = m4ct_pkg::FRAC_BITS_DEF,
    parameter int DIM       = m4ct_pkg::DIM_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // vector input channel
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire m4ct_pkg::t_vec_in                     i_data,
    // result output channel
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output m4ct_pkg::t_vec_out                         o_data,
    // matrix write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [m4ct_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [m4ct_pkg::REG_W-1:0]            i_cfg_data
);
    import m4ct_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(2 ** FRAC_BITS) >> 1;

    t_mat w_mat;

    // stage valids and advance enables
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_o_v;
    logic w_en_a, w_en_b, w_en_c, w_en_d, w_en_o;

    // stage payloads
    t_vec_in                              r_a_vec;
    logic signed [2*DATA_W-1:0]           r_b_prod [MAX_DIM][MAX_DIM];
    logic signed [ACC_W-1:0]              r_c_sum  [MAX_DIM][2];
    logic signed [ACC_W-1:0]              r_d_acc  [MAX_DIM];
    t_vec_out                             r_o_data;
    t_vec_out                             n_o_data;

    t_q                                   w_v      [MAX_DIM];
    logic signed [ACC_W-1:0]              w_shift  [MAX_DIM];
    t_q                                   w_row    [MAX_DIM];
    logic [MAX_DIM-1:0]                   w_sat;

    // matrix registers
    m4ct_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mat       (w_mat)
    );

    // a stage moves when it is empty or the next one moves
    assign w_en_o  = !r_o_v || !i_stall;
    assign w_en_d  = !r_d_v || w_en_o;
    assign w_en_c  = !r_c_v || w_en_d;
    assign w_en_b  = !r_b_v || w_en_c;
    assign w_en_a  = !r_a_v || w_en_b;
    assign o_stall = !w_en_a;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (w_en_a) r_a_v <= i_valid;
            if (w_en_b) r_b_v <= r_a_v;
            if (w_en_c) r_c_v <= r_b_v;
            if (w_en_d) r_d_v <= r_c_v;
            if (w_en_o) r_o_v <= r_d_v;
        end
    end

    // stage a: input beat register
    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_vec <= i_data;
        end
    end

    assign w_v[0] = r_a_vec.in_x;
    assign w_v[1] = r_a_vec.in_y;
    assign w_v[2] = r_a_vec.in_z;
    assign w_v[3] = r_a_vec.in_w;

    // stage b: one multiplier per matrix entry, unused columns and rows held at zero
    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            for (int r = 0; r < MAX_DIM; r++) begin
                for (int k = 0; k < MAX_DIM; k++) begin
                    if (r < DIM && k < DIM) begin
                        r_b_prod[r][k] <= w_mat[k][r] * w_v[k];
                    end else begin
                        r_b_prod[r][k] <= '0;
                    end
                end
            end
        end
    end

    // stage c: pairwise sums per row
    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            for (int r = 0; r < MAX_DIM; r++) begin
                r_c_sum[r][0] <= ACC_W'(r_b_prod[r][0]) + ACC_W'(r_b_prod[r][1]);
                r_c_sum[r][1] <= ACC_W'(r_b_prod[r][2]) + ACC_W'(r_b_prod[r][3]);
            end
        end
    end

    // stage d: full row sum plus rounding half
    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            for (int r = 0; r < MAX_DIM; r++) begin
                r_d_acc[r] <= r_c_sum[r][0] + r_c_sum[r][1] + ROUND_K;
            end
        end
    end

    // shift back and clip to 32 bits
    always_comb begin
        for (int r = 0; r < MAX_DIM; r++) begin
            w_shift[r] = r_d_acc[r] >>> FRAC_BITS;
            if (r >= DIM) begin
                w_row[r] = '0;
                w_sat[r] = 1'b0;
            end else if ((&w_shift[r][ACC_W-1:DATA_W-1]) ||
                         !(|w_shift[r][ACC_W-1:DATA_W-1])) begin
                w_row[r] = w_shift[r][DATA_W-1:0];
                w_sat[r] = 1'b0;
            end else begin
                w_row[r] = w_shift[r][ACC_W-1] ? SAT_MIN : SAT_MAX;
                w_sat[r] = 1'b1;
            end
        end
        n_o_data.out_x     = w_row[0];
        n_o_data.out_y     = w_row[1];
        n_o_data.out_z     = w_row[2];
        n_o_data.out_w     = w_row[3];
        n_o_data.saturated = |w_sat;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_data;

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // the flag comes only with a row sitting on a limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.saturated |->
            (o_data.out_x == SAT_MAX || o_data.out_x == SAT_MIN ||
             o_data.out_y == SAT_MAX || o_data.out_y == SAT_MIN ||
             o_data.out_z == SAT_MAX || o_data.out_z == SAT_MIN ||
             o_data.out_w == SAT_MAX || o_data.out_w == SAT_MIN))
        else $error("saturated flag without a clipped row");

    // input is held off only while stage a has a beat that cannot move
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_a_v && r_b_v && r_c_v && r_d_v && r_o_v)
        else $error("input stalled with a free stage");

    // a blocked beat in stage d stays put
    a_hold_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && !w_en_d |=> r_d_v && $stable(r_d_acc[0]))
        else $error("stage d beat lost while blocked");

endmodule
`default_nettype wire
